FILE: hw/rtl/lgs_pkg.sv
package lgs_pkg;

  localparam int LGS_GRID_SIZE = 64;

  localparam int ROW_W     = 64;
  localparam int ROW_IDX_W = 6;
  localparam int GEN_W     = 32;
  localparam int POP_W     = 13;
  localparam int CNT_W     = ROW_IDX_W + 1;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  // 3x3 window counts, cell included
  localparam logic [3:0] BORN_COUNT = 4'd3;
  localparam logic [3:0] KEEP_LOW   = 4'd3;
  localparam logic [3:0] KEEP_HIGH  = 4'd4;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_cells;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_data;
    logic [GEN_W-1:0] generation;
    logic [POP_W-1:0] population;
  } out_word_t;

  typedef struct packed {
    logic             latch;
    logic             wr_item;
    logic             rd_item;
    logic             sweep_start;
    logic             sweep_ev;
    logic             sweep_zero;
    logic [CNT_W-1:0] sweep_idx;
    logic             commit;
    logic             load_out;
  } lgs_cmd_t;

  typedef struct packed {
    logic out_free;
  } lgs_sts_t;

endpackage

FILE: hw/rtl/life_generation_step.sv
// Game of Life grid (B3/S23, no wrap) of GRID_SIZE x GRID_SIZE cells held in a row memory.
// Each input word writes a row, reads a row or advances one generation; every word gives
// exactly one result word with the read row (zero otherwise), the generation count and the
// population after the last step. A step runs a sweep that reads one row per cycle through the
// single read port of the row memory and a three-row window, writing each new row back
// through the s1 and s2 registers. Items are taken one at a time; a finished result may wait
// in the output register while the next word is accepted. Reset clears per-row valid bits,
// so the grid reads as all dead right after reset with no clearing pass.
module life_generation_step
  import lgs_pkg::*;
#(
  parameter int GRID_SIZE = LGS_GRID_SIZE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  lgs_cmd_t cmd;
  lgs_sts_t sts;

  lgs_ctrl #(
    .GRID_SIZE (GRID_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  lgs_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

FILE: hw/rtl/lgs_ctrl.sv
module lgs_ctrl
  import lgs_pkg::*;
#(
  parameter int GRID_SIZE = LGS_GRID_SIZE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_word,
  output logic      in_ready,
  input  lgs_sts_t  sts_i,
  output lgs_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_SWEEP   = 7'b0000100,
    S_DRAIN_A = 7'b0001000,
    S_DRAIN_B = 7'b0010000,
    S_COMMIT  = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              last_row;

  assign last_row = (cnt_r == CNT_W'(GRID_SIZE));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd_o     = '0;
    cmd_o.sweep_idx = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.latch = 1'b1;
          op_nxt      = in_word.operation;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_WRITE: begin
            cmd_o.wr_item = 1'b1;
            state_nxt     = S_RESP;
          end
          OP_READ: begin
            cmd_o.rd_item = 1'b1;
            state_nxt     = S_RESP;
          end
          OP_STEP: begin
            cmd_o.sweep_start = 1'b1;
            cnt_nxt           = '0;
            state_nxt         = S_SWEEP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep_ev   = 1'b1;
        cmd_o.sweep_zero = last_row;
        cnt_nxt          = cnt_r + CNT_W'(1);
        if (last_row) begin
          state_nxt = S_DRAIN_A;
        end
      end
      S_DRAIN_A: begin
        state_nxt = S_DRAIN_B;
      end
      S_DRAIN_B: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_WRITE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/lgs_dp.sv
module lgs_dp
  import lgs_pkg::*;
#(
  parameter int GRID_SIZE = LGS_GRID_SIZE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word,
  input  lgs_cmd_t  cmd_i,
  output lgs_sts_t  sts_o
);

  localparam int AW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

  function automatic logic [POP_W-1:0] popcnt(input logic [GRID_SIZE-1:0] v);
    logic [POP_W-1:0] s;
    s = '0;
    for (int i = 0; i < GRID_SIZE; i++) begin
      s = s + POP_W'(v[i]);
    end
    return s;
  endfunction

  // item latched at accept
  logic [OP_W-1:0]      op_r;
  logic [ROW_IDX_W-1:0] idx_r;
  logic [ROW_W-1:0]     cells_r;
  logic                 in_range;

  // row memory with per-row valid bits
  logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] vld_r;
  logic [GRID_SIZE-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa, mem_ra;
  logic [GRID_SIZE-1:0] mem_wd;

  // sweep pipeline
  logic                 s1_v_r, s1_zero_r;
  logic [CNT_W-1:0]     s1_idx_r, s1_prev;
  logic [GRID_SIZE-1:0] w_top_r, w_mid_r, x_row, new_row;
  logic                 s2_v_r;
  logic [AW-1:0]        s2_addr_r;
  logic [GRID_SIZE-1:0] s2_row_r;
  logic [POP_W-1:0]     acc_r;

  logic [GEN_W-1:0]     gen_r;
  logic [POP_W-1:0]     pop_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  assign in_range = ({1'b0, idx_r} < CNT_W'(GRID_SIZE));

  assign mem_we = s2_v_r | (cmd_i.wr_item & in_range);
  assign mem_wa = s2_v_r ? s2_addr_r : idx_r[AW-1:0];
  assign mem_wd = s2_v_r ? s2_row_r : cells_r[GRID_SIZE-1:0];
  assign mem_re = cmd_i.rd_item | cmd_i.sweep_ev;
  assign mem_ra = cmd_i.sweep_ev ? cmd_i.sweep_idx[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_r <= vld_r[mem_ra];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      op_r    <= in_word.operation;
      idx_r   <= in_word.row_index;
      cells_r <= in_word.row_cells;
    end
  end

  // next state of the center row from the three-row window
  assign x_row   = (s1_zero_r || !rd_vld_r) ? '0 : rd_data_r;
  assign s1_prev = s1_idx_r - CNT_W'(1);

  always_comb begin
    logic [GRID_SIZE+1:0] pt, pm, pb;
    logic [3:0]           n9;
    pt      = {1'b0, w_top_r, 1'b0};
    pm      = {1'b0, w_mid_r, 1'b0};
    pb      = {1'b0, x_row, 1'b0};
    new_row = '0;
    for (int j = 0; j < GRID_SIZE; j++) begin
      n9 = 4'(pt[j]) + 4'(pt[j+1]) + 4'(pt[j+2])
         + 4'(pm[j]) + 4'(pm[j+1]) + 4'(pm[j+2])
         + 4'(pb[j]) + 4'(pb[j+1]) + 4'(pb[j+2]);
      new_row[j] = pm[j+1] ? ((n9 == KEEP_LOW) || (n9 == KEEP_HIGH)) : (n9 == BORN_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_zero_r <= 1'b0;
      s1_idx_r  <= '0;
      s2_v_r    <= 1'b0;
      s2_addr_r <= '0;
      w_top_r   <= '0;
      w_mid_r   <= '0;
      acc_r     <= '0;
    end else begin
      s1_v_r    <= cmd_i.sweep_ev;
      s1_zero_r <= cmd_i.sweep_zero;
      s1_idx_r  <= cmd_i.sweep_idx;
      s2_v_r    <= s1_v_r && (s1_idx_r != '0);
      s2_addr_r <= s1_prev[AW-1:0];
      if (cmd_i.sweep_start) begin
        w_top_r <= '0;
        w_mid_r <= '0;
      end else if (s1_v_r) begin
        w_top_r <= w_mid_r;
        w_mid_r <= x_row;
      end
      if (cmd_i.sweep_start) begin
        acc_r <= '0;
      end else if (s2_v_r) begin
        acc_r <= acc_r + popcnt(s2_row_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_row_r <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= '0;
      pop_r <= '0;
    end else if (cmd_i.commit) begin
      gen_r <= gen_r + GEN_W'(1);
      pop_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_word_r.row_data   <= ((op_r == OP_READ) && in_range && rd_vld_r) ?
                               ROW_W'(rd_data_r) : '0;
      out_word_r.generation <= gen_r;
      out_word_r.population <= pop_r;
    end
  end

  assign sts_o.out_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;

endmodule
